// ===== design/tfwp_pkg.sv =====
`timescale 1ns / 1ps
package tfwp_pkg;

  localparam int FRAME_BYTES_DEF = 60;
  localparam int FRAME_BYTES_MIN = 52;
  localparam int FRAME_BYTES_MAX = 256;
  localparam int SYNC_BYTES      = 4;
  localparam int OFS_NUMBER      = 12;
  localparam int OFS_POS         = 28;
  localparam int POS_WORDS       = 6;

  localparam logic [31:0] PREAMBLE_RESET = 32'h5052_5056;

  typedef logic [7:0]  byte_t;
  typedef logic [31:0] word_t;

  typedef struct packed {
    word_t frame_number;
    word_t pos_x;
    word_t pos_y;
    word_t pos_z;
    word_t azimuth;
    word_t elevation;
    word_t roll;
  } frame_fields_t;

  // window state handed from the cell row to the result stage
  typedef struct packed {
    logic  pend;
    word_t head_word;
    word_t tail_word;
  } sync_view_t;

endpackage

// ===== design/tfwp_cell.sv =====
`timescale 1ns / 1ps
module tfwp_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            shift_en,
  input  tfwp_pkg::byte_t d_in,
  output tfwp_pkg::byte_t q
);

  tfwp_pkg::byte_t byte_r;
  tfwp_pkg::byte_t byte_nxt;

  always_comb begin
    byte_nxt = byte_r;
    if (shift_en) begin
      byte_nxt = d_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_r <= '0;
    end else begin
      byte_r <= byte_nxt;
    end
  end

  assign q = byte_r;

endmodule

// ===== design/tfwp_result.sv =====
`timescale 1ns / 1ps
module tfwp_result (
  input  logic                    clk,
  input  logic                    rst_n,
  input  tfwp_pkg::sync_view_t    view,
  input  tfwp_pkg::word_t         preamble,
  input  tfwp_pkg::frame_fields_t fields,
  input  logic                    out_ready,
  output logic                    out_valid,
  output tfwp_pkg::frame_fields_t out_data,
  output logic                    hit,
  output logic                    blocked
);

  logic                    valid_r;
  logic                    valid_nxt;
  tfwp_pkg::frame_fields_t data_r;
  tfwp_pkg::frame_fields_t data_nxt;
  logic                    slot_free;
  logic                    load;

  assign hit       = view.pend && (view.head_word == preamble) && (view.tail_word == preamble);
  assign slot_free = !valid_r || out_ready;
  assign load      = hit && slot_free;
  // a matched window waits here until the output slot drains
  assign blocked   = hit && !slot_free;

  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    if (load) begin
      valid_nxt = 1'b1;
      data_nxt  = fields;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

// ===== design/tracker_frame_window_parser_unit.sv =====
`timescale 1ns / 1ps
// frame finder for a serial position tracker
// in_*  : one received byte per beat (in_valid / in_ready)
// out_* : one decoded frame per beat (out_valid / out_ready): frame number at
//         offset 12 and six raw position / orientation words at offsets 28..48
// cfg_* : cfg_wr_en writes the 32-bit preamble, first byte in bits 7:0; write
//         it only while no byte is in flight
// bytes shift through a row of FRAME_BYTES + 4 byte cells; a frame is found
// when the oldest four bytes and the four bytes FRAME_BYTES later both equal
// the preamble, and the frame is the one starting at the oldest byte
// path: a frame's last byte sets the row and pend_r; a match then sets out_valid
// throughput: one byte per cycle while in_ready is high (single row shift)
// reset: the cell row clears to zeros, the preamble returns to "VPRP", no
// result is pending
// stall: while out_ready is low the result holds; a further match that finds
// the output slot full holds the row and drops in_ready until the slot drains
module tracker_frame_window_parser_unit #(
  parameter int FRAME_BYTES = tfwp_pkg::FRAME_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_frame_number,
  output logic [31:0] out_pos_x,
  output logic [31:0] out_pos_y,
  output logic [31:0] out_pos_z,
  output logic [31:0] out_azimuth,
  output logic [31:0] out_elevation,
  output logic [31:0] out_roll,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data
);

  localparam int WIN_LEN = FRAME_BYTES + tfwp_pkg::SYNC_BYTES;

  tfwp_pkg::byte_t         win [WIN_LEN];
  tfwp_pkg::word_t         preamble_r;
  tfwp_pkg::word_t         preamble_nxt;
  logic                    pend_r;
  logic                    pend_nxt;
  logic                    in_fire;
  logic                    hit;
  logic                    blocked;
  tfwp_pkg::sync_view_t    view;
  tfwp_pkg::frame_fields_t fields;
  tfwp_pkg::frame_fields_t out_data;
  tfwp_pkg::word_t         pos_words [tfwp_pkg::POS_WORDS];

  assign in_ready = !blocked;
  assign in_fire  = in_valid && in_ready;

  // newest byte enters the top cell, each cell takes its upper neighbor
  for (genvar i = 0; i < WIN_LEN; i++) begin : g_cell
    tfwp_pkg::byte_t d;
    if (i == WIN_LEN - 1) begin : g_top
      assign d = in_rx_byte;
    end else begin : g_mid
      assign d = win[i+1];
    end
    tfwp_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (in_fire),
      .d_in     (d),
      .q        (win[i])
    );
  end

  for (genvar k = 0; k < tfwp_pkg::POS_WORDS; k++) begin : g_pos
    localparam int OFS = tfwp_pkg::OFS_POS + 4 * k;
    assign pos_words[k] = {win[OFS+3], win[OFS+2], win[OFS+1], win[OFS]};
  end

  always_comb begin
    fields.frame_number = {win[tfwp_pkg::OFS_NUMBER+3], win[tfwp_pkg::OFS_NUMBER+2],
                           win[tfwp_pkg::OFS_NUMBER+1], win[tfwp_pkg::OFS_NUMBER]};
    fields.pos_x        = pos_words[0];
    fields.pos_y        = pos_words[1];
    fields.pos_z        = pos_words[2];
    fields.azimuth      = pos_words[3];
    fields.elevation    = pos_words[4];
    fields.roll         = pos_words[5];
  end

  always_comb begin
    view.pend      = pend_r;
    view.head_word = {win[3], win[2], win[1], win[0]};
    view.tail_word = {win[FRAME_BYTES+3], win[FRAME_BYTES+2],
                      win[FRAME_BYTES+1], win[FRAME_BYTES]};
  end

  // pend_r: the row moved and its new contents are still to be judged
  always_comb begin
    pend_nxt     = in_fire || blocked;
    preamble_nxt = preamble_r;
    if (cfg_wr_en) begin
      preamble_nxt = cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r     <= 1'b0;
      preamble_r <= tfwp_pkg::PREAMBLE_RESET;
    end else begin
      pend_r     <= pend_nxt;
      preamble_r <= preamble_nxt;
    end
  end

  tfwp_result u_result (
    .clk       (clk),
    .rst_n     (rst_n),
    .view      (view),
    .preamble  (preamble_r),
    .fields    (fields),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .hit       (hit),
    .blocked   (blocked)
  );

  assign out_frame_number = out_data.frame_number;
  assign out_pos_x        = out_data.pos_x;
  assign out_pos_y        = out_data.pos_y;
  assign out_pos_z        = out_data.pos_z;
  assign out_azimuth      = out_data.azimuth;
  assign out_elevation    = out_data.elevation;
  assign out_roll         = out_data.roll;

  a_accept_pends: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> pend_r)
    else $error("accepted beat left no pending evaluation");

  a_row_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !in_fire |=> $stable(win[0]) && $stable(win[WIN_LEN-1]))
    else $error("cell row moved without an accepted beat");

  a_new_result_from_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid || out_ready) && !hit |=> !out_valid)
    else $error("result appeared without a matched window");

  a_blocked_holds: assert property (@(posedge clk) disable iff (!rst_n)
    blocked |-> !in_ready ##1 pend_r)
    else $error("matched window lost while output was stalled");

endmodule
